// ===== hw/rtl/srpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srpf_pkg;

    localparam int DEF_NUM_SETS    = 2048;
    localparam int DEF_NUM_WAYS    = 16;
    localparam int DEF_SIG_ENTRIES = 4096;

    localparam int SET_FIELD_W = 11;
    localparam int WAY_FIELD_W = 4;
    localparam int PC_W        = 24;
    localparam int SIG_W       = 12;
    localparam int RR_W        = 2;
    localparam int CNT_W       = 8;

    localparam logic [RR_W-1:0]  RR_MAX      = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;
    localparam logic [CNT_W-1:0] THR_RESET   = 8'd1;

    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MOD   = 6'b000100,
        S_READ  = 6'b001000,
        S_ROW   = 6'b010000,
        S_CNT   = 6'b100000
    } state_t;

    // address width of a memory, at least one bit
    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srrip_pc_frequency_replacement.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Replacement policy of a set-associative cache (SRRIP with signature-based insertion).
// Input stream s_*: one transfer per replacement access. s_tuser[0] = kind (0 victim
// request, 1 update), s_tuser[1] = hit. A victim request returns one transfer on m_*
// carrying the victim way; an update returns nothing.
// cfg_*: writes hot_threshold (reset value 1); cfg_ready is always high.
// Per-set state (2-bit re-reference value, reused flag, counter-table index per way)
// is one row of a set memory; the frequency counters sit in a second memory.
// Steps: a victim request reads its row, then writes back the aged row and loads its
// victim way into the output register that drives m_tvalid. The steps of an update are a
// row read, counter read of the evicted signature, then write back of row and counter.
// When NUM_SETS is below 2048 and not a power of two (or is 1), or SIG_ENTRIES is below
// 4096 and not a power of two, an S_MOD state reduces the set and signature indexes first.
// Reset: after aresetn is released, a clearing pass writes max(NUM_SETS, SIG_ENTRIES)
// rows, one per cycle; s_tready stays low meanwhile.
// Stall: the result sits in an output register; a new item is still taken while it
// waits, but the next victim result holds back until the register is free.

module srrip_pc_frequency_replacement
    import srpf_pkg::*;
#(
    parameter int NUM_SETS    = DEF_NUM_SETS,
    parameter int NUM_WAYS    = DEF_NUM_WAYS,
    parameter int SIG_ENTRIES = DEF_SIG_ENTRIES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // set_index[10:0], way_index[14:11], pc[38:15]
    input  wire logic [1:0]           s_tuser,   // kind[0], hit[1]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // victim_way[3:0]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CNT_W-1:0]     cfg_data
);

    localparam int SET_AW = addr_w(NUM_SETS);
    localparam int SIG_AW = addr_w(SIG_ENTRIES);
    localparam int FW     = RR_W + 1 + SIG_AW;
    localparam int ROW_W  = NUM_WAYS * FW;
    localparam int CLR_N  = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W  = addr_w(CLR_N);
    localparam bit SET_MOD = (NUM_SETS < 2048) &&
                             (((NUM_SETS & (NUM_SETS - 1)) != 0) || (NUM_SETS == 1));
    localparam bit SIG_MOD = (SIG_ENTRIES < 4096) && ((SIG_ENTRIES & (SIG_ENTRIES - 1)) != 0);
    localparam bit MOD_NEEDED = SET_MOD || SIG_MOD;
    localparam logic MOD_FIRST = 1'b1;
    localparam int RECIP_SH  = 24;
    localparam int PROD_W    = SIG_W + RECIP_SH;
    localparam int SET_RECIP = (1 << RECIP_SH) / NUM_SETS + 1;
    localparam int SIG_RECIP = (1 << RECIP_SH) / SIG_ENTRIES + 1;

    state_t                   state_reg, state_next;
    logic [CLR_W-1:0]         clr_reg;
    logic                     kind_reg, hit_reg;
    logic [WAY_FIELD_W-1:0]   way_reg;
    logic [SET_FIELD_W-1:0]   mod_set_reg;
    logic [SIG_W-1:0]         mod_sig_reg;
    logic                     step_reg;
    logic [SET_FIELD_W-1:0]   set_q_reg;
    logic [SIG_W-1:0]         sig_q_reg;
    logic [CNT_W-1:0]         newcnt_reg;
    logic [CNT_W-1:0]         thr_reg;
    logic                     m_valid_reg;
    logic [WAY_FIELD_W-1:0]   victim_reg;

    logic                     row_we, row_re;
    logic [SET_AW-1:0]        row_waddr, set_addr;
    logic [ROW_W-1:0]         row_wdata, row_rdata, row_aged, row_upd, row_clear;
    logic                     cnt_we, cnt_re;
    logic [SIG_AW-1:0]        cnt_waddr, cnt_raddr, new_sig, old_sig;
    logic [CNT_W-1:0]         cnt_wdata, cnt_rdata, trained, hot_cnt;
    logic                     old_reused;
    logic [WAY_FIELD_W-1:0]   victim_way;
    logic                     s_xfer, way_ok, out_free, load_out;
    logic [PROD_W-1:0]        set_prod, sig_prod;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - WAY_FIELD_W){1'b0}}, victim_reg};
    assign s_xfer    = s_tvalid && s_tready;
    assign way_ok    = (32'(s_tdata[14:11]) < NUM_WAYS);
    assign out_free  = !m_valid_reg || m_tready;
    assign set_addr  = SET_AW'(mod_set_reg);
    assign new_sig   = SIG_AW'(mod_sig_reg);
    assign set_prod  = PROD_W'(mod_set_reg) * PROD_W'(SET_RECIP);
    assign sig_prod  = PROD_W'(mod_sig_reg) * PROD_W'(SIG_RECIP);

    srpf_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (set_addr),
        .rdata (row_rdata)
    );

    srpf_ram #(.WIDTH(CNT_W), .DEPTH(SIG_ENTRIES)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // selected way of the row just read
    always_comb begin
        old_sig    = '0;
        old_reused = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == int'(way_reg)) begin
                old_reused = row_rdata[w*FW + RR_W];
                old_sig    = row_rdata[w*FW + RR_W + 1 +: SIG_AW];
            end
        end
    end

    // aging and victim choice in one step: raise every way by 3 minus the row maximum
    always_comb begin
        logic [RR_W-1:0] mx;
        logic [RR_W-1:0] add;
        logic            found;
        mx         = '0;
        found      = 1'b0;
        victim_way = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (row_rdata[w*FW +: RR_W] > mx) begin
                mx = row_rdata[w*FW +: RR_W];
            end
        end
        add      = RR_MAX - mx;
        row_aged = row_rdata;
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_aged[w*FW +: RR_W] = row_rdata[w*FW +: RR_W] + add;
            if (!found && (row_aged[w*FW +: RR_W] == RR_MAX)) begin
                victim_way = WAY_FIELD_W'(w);
                found      = 1'b1;
            end
        end
    end

    // counter training and insertion position
    always_comb begin
        if (hit_reg || old_reused) begin
            trained = (cnt_rdata == CNT_MAX) ? CNT_MAX : cnt_rdata + 1'b1;
        end else begin
            trained = (cnt_rdata == '0) ? '0 : cnt_rdata - 1'b1;
        end
        // a fill whose new signature shares the evicted one's counter sees the trained value
        hot_cnt = (old_sig == new_sig) ? trained : newcnt_reg;
        row_upd = row_rdata;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == int'(way_reg)) begin
                if (hit_reg) begin
                    row_upd[w*FW +: RR_W]  = '0;
                    row_upd[w*FW + RR_W]   = 1'b1;
                end else begin
                    row_upd[w*FW +: RR_W]  = (hot_cnt >= thr_reg) ? '0 : RR_MAX;
                    row_upd[w*FW + RR_W]   = 1'b0;
                    row_upd[w*FW + RR_W + 1 +: SIG_AW] = new_sig;
                end
            end
        end
    end

    always_comb begin
        row_clear = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            row_clear[w*FW +: RR_W] = RR_MAX;
        end
    end

    always_comb begin
        state_next = state_reg;
        row_we     = 1'b0;
        row_re     = 1'b0;
        row_waddr  = set_addr;
        row_wdata  = row_aged;
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_waddr  = old_sig;
        cnt_wdata  = trained;
        cnt_raddr  = new_sig;
        load_out   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                row_we    = (32'(clr_reg) < NUM_SETS);
                row_waddr = SET_AW'(clr_reg);
                row_wdata = row_clear;
                cnt_we    = (32'(clr_reg) < SIG_ENTRIES);
                cnt_waddr = SIG_AW'(clr_reg);
                cnt_wdata = '0;
                if (32'(clr_reg) == CLR_N - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_xfer && (s_tuser[0] == KIND_VICTIM || way_ok)) begin
                    state_next = MOD_NEEDED ? S_MOD : S_READ;
                end
            end
            S_MOD: begin
                if (step_reg == '0) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                row_re     = 1'b1;
                cnt_re     = 1'b1;
                state_next = S_ROW;
            end
            S_ROW: begin
                if (kind_reg == KIND_VICTIM) begin
                    if (out_free) begin
                        row_we     = 1'b1;
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = old_sig;
                    state_next = S_CNT;
                end
            end
            S_CNT: begin
                row_we     = 1'b1;
                row_wdata  = row_upd;
                cnt_we     = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            thr_reg     <= THR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            kind_reg    <= s_tuser[0];
            hit_reg     <= s_tuser[1];
            way_reg     <= s_tdata[14:11];
            mod_set_reg <= s_tdata[10:0];
            mod_sig_reg <= s_tdata[26:15] ^ s_tdata[38:27];
            step_reg    <= MOD_FIRST;
        end else if (state_reg == S_MOD) begin
            // quotient by reciprocal multiplication, remainder on the next cycle
            if (step_reg == MOD_FIRST) begin
                set_q_reg <= set_prod[RECIP_SH +: SET_FIELD_W];
                sig_q_reg <= sig_prod[RECIP_SH +: SIG_W];
            end else begin
                if (SET_MOD) begin
                    mod_set_reg <= SET_FIELD_W'(32'(mod_set_reg) -
                                                32'(set_q_reg) * 32'(NUM_SETS));
                end
                if (SIG_MOD) begin
                    mod_sig_reg <= SIG_W'(32'(mod_sig_reg) -
                                          32'(sig_q_reg) * 32'(SIG_ENTRIES));
                end
            end
            step_reg <= step_reg - 1'b1;
        end
        if (state_reg == S_ROW) begin
            newcnt_reg <= cnt_rdata;
        end
        if (load_out) begin
            victim_reg <= victim_way;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/srpf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srpf_ram
    import srpf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [addr_w(DEPTH)-1:0]  waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [addr_w(DEPTH)-1:0]  raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/srpf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srpf_checker
    import srpf_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [1:0]           s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // reset starts the clearing pass with no result pending
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("port active right after reset");

    // one item at a time: a victim request closes the input for its work
    a_victim_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == KIND_VICTIM |=> !s_tready)
        else $error("input still open after a victim request");

    // a result needs at least the row read before it shows
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result shown one cycle after the request");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'd0)
        else $error("padding bits of result not zero");

endmodule

bind srrip_pc_frequency_replacement srpf_checker u_srpf_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import srpf_pkg::*;
();

    localparam int WAY_ROWS      = DEF_NUM_SETS * DEF_NUM_WAYS;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 120;
    localparam int PC_POOL_N     = 6;
    localparam int DIR_N         = 16;

    typedef struct packed {
        logic                   kind;
        logic [SET_FIELD_W-1:0] set_idx;
        logic [WAY_FIELD_W-1:0] way;
        logic [PC_W-1:0]        pc;
        logic                   hit;
    } access_t;

    typedef struct packed {
        access_t                acc;
        logic                   typed;
        logic [WAY_FIELD_W-1:0] want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data  = '0;

    // policy state as seen from outside
    logic [RR_W-1:0]  rrpv_mem   [WAY_ROWS];
    logic             reused_mem [WAY_ROWS];
    logic [SIG_W-1:0] sig_mem    [WAY_ROWS];
    logic [CNT_W-1:0] freq_cnt   [DEF_SIG_ENTRIES];
    logic [CNT_W-1:0] hot_thr;

    logic [WAY_FIELD_W-1:0] victim_q [$];
    logic [WAY_FIELD_W-1:0] last_victim;
    int                     mismatch_cnt = 0;

    dir_row_t               dir_rows [DIR_N];
    logic [SET_FIELD_W-1:0] set_pool [4];
    logic [PC_W-1:0]        pc_pool  [PC_POOL_N];
    bit                     sender_idles = 1'b1;
    int                     burst_left   = 0;

    int results_seen = 0;
    int hold_cnt     = 0;
    bit hold_done    = 1'b0;
    int rx_mode      = 0;
    int mode_timer   = 0;
    int idle_cycles  = 0;

    srrip_pc_frequency_replacement i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    function automatic void reset_policy();
        for (int i = 0; i < WAY_ROWS; i++) begin
            rrpv_mem[i]   = RR_MAX;
            reused_mem[i] = 1'b0;
            sig_mem[i]    = '0;
        end
        for (int i = 0; i < DEF_SIG_ENTRIES; i++) begin
            freq_cnt[i] = '0;
        end
        hot_thr = THR_RESET;
    endfunction

    function automatic void count_up(input logic [SIG_W-1:0] sig);
        int idx;
        idx = int'(sig) % DEF_SIG_ENTRIES;
        if (freq_cnt[idx] != CNT_MAX) begin
            freq_cnt[idx] = freq_cnt[idx] + 1'b1;
        end
    endfunction

    function automatic void count_down(input logic [SIG_W-1:0] sig);
        int idx;
        idx = int'(sig) % DEF_SIG_ENTRIES;
        if (freq_cnt[idx] != '0) begin
            freq_cnt[idx] = freq_cnt[idx] - 1'b1;
        end
    endfunction

    // applies one access to the policy state; returns 1 when it yields a victim
    function automatic bit rrip_step(input access_t a, output logic [WAY_FIELD_W-1:0] vic);
        int               base;
        int               e;
        logic [RR_W-1:0]  top;
        logic [SIG_W-1:0] new_sig;
        bit               found;
        base = (int'(a.set_idx) % DEF_NUM_SETS) * DEF_NUM_WAYS;
        vic  = '0;
        if (a.kind == KIND_VICTIM) begin
            top = '0;
            for (int w = 0; w < DEF_NUM_WAYS; w++) begin
                if (rrpv_mem[base + w] > top) top = rrpv_mem[base + w];
            end
            // one-shot aging: lift the whole set so its oldest way sits at max
            for (int w = 0; w < DEF_NUM_WAYS; w++) begin
                rrpv_mem[base + w] = rrpv_mem[base + w] + (RR_MAX - top);
            end
            found = 1'b0;
            for (int w = 0; w < DEF_NUM_WAYS; w++) begin
                if (!found && rrpv_mem[base + w] == RR_MAX) begin
                    vic   = w[WAY_FIELD_W-1:0];
                    found = 1'b1;
                end
            end
            return 1'b1;
        end
        e = base + int'(a.way);
        if (a.hit) begin
            rrpv_mem[e]   = '0;
            reused_mem[e] = 1'b1;
            count_up(sig_mem[e]);
        end else begin
            new_sig = a.pc[SIG_W-1:0] ^ a.pc[PC_W-1:SIG_W];
            // train on the block being evicted before inserting
            if (reused_mem[e]) count_up(sig_mem[e]);
            else count_down(sig_mem[e]);
            sig_mem[e]    = new_sig;
            reused_mem[e] = 1'b0;
            if (freq_cnt[int'(new_sig) % DEF_SIG_ENTRIES] >= hot_thr) rrpv_mem[e] = '0;
            else rrpv_mem[e] = RR_MAX;
        end
        return 1'b0;
    endfunction

    function automatic access_t random_access();
        access_t a;
        a.kind    = 1'($urandom_range(0, 1));
        a.set_idx = SET_FIELD_W'($urandom_range(0, DEF_NUM_SETS - 1));
        a.way     = WAY_FIELD_W'($urandom_range(0, DEF_NUM_WAYS - 1));
        a.pc      = PC_W'($urandom_range(0, 24'hFF_FFFF));
        a.hit     = 1'($urandom_range(0, 1));
        return a;
    endfunction

    task automatic pace();
        int gap;
        if (sender_idles && hold_cnt == 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_access(input access_t a, input logic typed,
                               input logic [WAY_FIELD_W-1:0] want);
        logic [WAY_FIELD_W-1:0] vic;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, a.pc, a.way, a.set_idx};
        s_tuser  <= {a.hit, a.kind};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (rrip_step(a, vic)) begin
            last_victim = vic;
            victim_q.push_back(typed ? want : vic);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (victim_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        hot_thr = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int n_items, input int acc_w, input int hit_w,
                             input int fill_w, input bit sig0_pcs, input bit fresh_sets,
                             input int npool, input bit idles);
        access_t          a;
        int               done;
        int               r;
        logic [SIG_W-1:0] h;
        logic [SIG_W-1:0] s0;
        sender_idles = idles;
        if (fresh_sets) begin
            for (int i = 0; i < 4; i++) begin
                set_pool[i] = SET_FIELD_W'($urandom_range(0, DEF_NUM_SETS - 1));
            end
        end
        for (int i = 0; i < PC_POOL_N; i++) begin
            h = SIG_W'($urandom_range(0, 12'hFFF));
            // equal halves fold to signature zero
            if (sig0_pcs) pc_pool[i] = {h, h};
            else pc_pool[i] = PC_W'($urandom_range(0, 24'hFF_FFFF));
        end
        if (!sig0_pcs) begin
            // force a second pc onto the first one's signature
            s0 = pc_pool[0][SIG_W-1:0] ^ pc_pool[0][PC_W-1:SIG_W];
            h  = SIG_W'($urandom_range(0, 12'hFFF));
            pc_pool[1] = {h, h ^ s0};
        end
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 99);
            a = random_access();
            a.set_idx = set_pool[$urandom_range(0, npool - 1)];
            if (r < acc_w) begin
                a.kind = KIND_VICTIM;
                pace();
                send_access(a, 1'b0, '0);
                a.kind = KIND_UPDATE;
                a.way  = last_victim;
                a.pc   = pc_pool[$urandom_range(0, PC_POOL_N - 1)];
                a.hit  = 1'b0;
                pace();
                send_access(a, 1'b0, '0);
                done += 2;
            end else if (r < acc_w + hit_w) begin
                a.kind = KIND_UPDATE;
                a.hit  = 1'b1;
                pace();
                send_access(a, 1'b0, '0);
                done++;
            end else if (r < acc_w + hit_w + fill_w) begin
                a.kind = KIND_UPDATE;
                a.hit  = 1'b0;
                a.pc   = pc_pool[$urandom_range(0, PC_POOL_N - 1)];
                pace();
                send_access(a, 1'b0, '0);
                done++;
            end else begin
                a = random_access();
                pace();
                send_access(a, 1'b0, '0);
                done++;
            end
        end
    endtask

    // result side: check against the oldest expectation, then pick the next tready
    always @(posedge aclk) begin : result_side
        logic [WAY_FIELD_W-1:0] want;
        if (m_tvalid === 1'b1 && m_tready) begin
            results_seen <= results_seen + 1;
            if (victim_q.size() == 0) begin
                $display("%0t: victim_way expected none, actual %0d", $time,
                         m_tdata[WAY_FIELD_W-1:0]);
                mismatch_cnt++;
            end else begin
                want = victim_q.pop_front();
                if (m_tdata[WAY_FIELD_W-1:0] !== want) begin
                    $display("%0t: victim_way expected %0d, actual %0d", $time, want,
                             m_tdata[WAY_FIELD_W-1:0]);
                    mismatch_cnt++;
                end
            end
        end
        if (mode_timer == 0) begin
            rx_mode    <= $urandom_range(0, 3);
            mode_timer <= 300;
        end else begin
            mode_timer <= mode_timer - 1;
        end
        if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= ($urandom_range(0, 9) < 7);
                end
                2: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= (mode_timer % 3 != 0);
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        dir_rows = '{
            // victim request ignores way, pc and hit; fresh set is all max
            '{'{KIND_VICTIM, 11'd0,    4'd15, 24'hFF_FFFF, 1'b1}, 1'b1, 4'd0},
            '{'{KIND_VICTIM, 11'd2047, 4'd0,  24'h00_0000, 1'b0}, 1'b1, 4'd0},
            '{'{KIND_UPDATE, 11'd0,    4'd0,  24'hFF_FFFF, 1'b1}, 1'b0, 4'd0},
            '{'{KIND_VICTIM, 11'd0,    4'd0,  24'h00_0000, 1'b0}, 1'b1, 4'd1},
            '{'{KIND_UPDATE, 11'd0,    4'd1,  24'h00_0000, 1'b1}, 1'b0, 4'd0},
            '{'{KIND_UPDATE, 11'd0,    4'd15, 24'h00_0000, 1'b1}, 1'b0, 4'd0},
            '{'{KIND_VICTIM, 11'd0,    4'd7,  24'h5A_5A5A, 1'b1}, 1'b1, 4'd2},
            // fill over a block that was never reused
            '{'{KIND_UPDATE, 11'd2047, 4'd15, 24'hFF_FFFF, 1'b0}, 1'b0, 4'd0},
            '{'{KIND_VICTIM, 11'd2047, 4'd0,  24'h00_0000, 1'b0}, 1'b1, 4'd0},
            '{'{KIND_UPDATE, 11'd2047, 4'd0,  24'h12_3456, 1'b0}, 1'b0, 4'd0},
            '{'{KIND_VICTIM, 11'd2047, 4'd3,  24'h00_0000, 1'b1}, 1'b1, 4'd0},
            '{'{KIND_UPDATE, 11'd2047, 4'd0,  24'h00_0000, 1'b1}, 1'b0, 4'd0},
            '{'{KIND_UPDATE, 11'd2047, 4'd1,  24'h12_3456, 1'b0}, 1'b0, 4'd0},
            '{'{KIND_VICTIM, 11'd2047, 4'd0,  24'h00_0000, 1'b0}, 1'b0, 4'd0},
            // fill over a reused block trains its counter upward
            '{'{KIND_UPDATE, 11'd0,    4'd0,  24'hAB_CDEF, 1'b0}, 1'b0, 4'd0},
            '{'{KIND_VICTIM, 11'd0,    4'd0,  24'h00_0000, 1'b0}, 1'b0, 4'd0}
        };
        reset_policy();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            pace();
            send_access(dir_rows[i].acc, dir_rows[i].typed, dir_rows[i].want);
        end

        set_pool[0] = '0;
        set_pool[1] = SET_FIELD_W'(DEF_NUM_SETS - 1);
        set_pool[2] = SET_FIELD_W'($urandom_range(0, DEF_NUM_SETS - 1));
        set_pool[3] = SET_FIELD_W'($urandom_range(0, DEF_NUM_SETS - 1));
        drain_results();
        write_threshold(8'd3);
        run_phase(220, 40, 35, 10, 1'b0, 1'b0, 4, 1'b1);
        drain_results();
        write_threshold(8'd0);
        run_phase(200, 40, 40, 10, 1'b0, 1'b1, 4, 1'b0);
        drain_results();
        write_threshold(CNT_MAX);
        run_phase(200, 40, 40, 10, 1'b0, 1'b1, 4, 1'b1);
        // hammer one set with hits so signature zero saturates high
        drain_results();
        write_threshold(8'd200);
        run_phase(400, 2, 95, 3, 1'b1, 1'b1, 1, 1'b1);
        // then drain it to zero with fills of never-reused blocks
        drain_results();
        write_threshold(CNT_MAX);
        run_phase(380, 20, 0, 80, 1'b1, 1'b0, 1, 1'b1);
        drain_results();
        write_threshold(CNT_W'($urandom_range(0, 255)));
        run_phase(200, 40, 40, 10, 1'b0, 1'b1, 4, 1'b1);
        drain_results();
        write_threshold(8'd128);
        run_phase(150, 45, 45, 5, 1'b0, 1'b1, 2, 1'b0);
        drain_results();
        write_threshold(8'd1);
        run_phase(150, 30, 30, 20, 1'b0, 1'b1, 4, 1'b1);
        drain_results();

        if (mismatch_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
